// File: hw/rtl/mono_oled_frame_buffer_assert.svh
// Assertion macros for the monochrome OLED frame buffer.
// Each use expects signals named clk and rst_n in the including scope.
`ifndef MONO_OLED_FRAME_BUFFER_ASSERT_SVH
`define MONO_OLED_FRAME_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MOFB_ASSERT_NOW(label, cond, expect_now) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_now)) \
    else $error("frame buffer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define MOFB_ASSERT_NEXT(label, cond, expect_next) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
    else $error("frame buffer check failed one cycle later");

`endif

// File: hw/rtl/mofb_pkg.sv
// Shared types and constants of the monochrome OLED frame buffer.
// No dependencies; used by the controller, the datapath and the top level.
package mofb_pkg;

  // Default panel geometry.
  localparam int DEF_COLUMNS = 128;
  localparam int DEF_PAGES   = 8;

  // Operation codes of an input item.
  localparam logic [2:0] OP_SET_PIXEL   = 3'd0;
  localparam logic [2:0] OP_CLEAR_PIXEL = 3'd1;
  localparam logic [2:0] OP_FILL_RECT   = 3'd2;
  localparam logic [2:0] OP_CLEAR_ALL   = 3'd3;
  localparam logic [2:0] OP_REFRESH     = 3'd4;

  // Panel commands that open each page of the refresh stream.
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // Kind of work an accepted item needs.
  typedef enum logic [1:0] {
    JOB_NONE    = 2'd0,
    JOB_RMW     = 2'd1,
    JOB_CLEAR   = 2'd2,
    JOB_REFRESH = 2'd3
  } job_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic walk_step;
    logic mem_rd;
    logic mem_wr;
    logic mem_clr;
    logic load_out;
    logic refresh;
  } mofb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    job_t in_job;
    logic walk_last;
    logic out_free;
  } mofb_status_t;

endpackage

// File: hw/rtl/mofb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mofb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/mofb_ctrl.sv
// Controller state machine of the monochrome OLED frame buffer.
// Depends on mofb_pkg for the command, status and job types.
module mofb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mofb_pkg::mofb_status_t status,
  output mofb_pkg::mofb_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CLEAR = 6'b000100,
    S_READ  = 6'b001000,
    S_WRITE = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  mofb_pkg::job_t      job_r, job_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    cmd       = '0;
    in_ready  = 1'b0;
    cmd.refresh = (job_r == mofb_pkg::JOB_REFRESH);
    unique case (state_r)
      S_INIT: begin
        // Clearing pass over the whole store after reset.
        cmd.mem_clr = 1'b1;
        if (status.walk_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          job_nxt     = status.in_job;
          unique case (status.in_job)
            mofb_pkg::JOB_RMW:     state_nxt = S_READ;
            mofb_pkg::JOB_REFRESH: state_nxt = S_READ;
            mofb_pkg::JOB_CLEAR:   state_nxt = S_CLEAR;
            default:               state_nxt = S_RESP;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.mem_clr = 1'b1;
        if (status.walk_last) begin
          state_nxt = S_RESP;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = (job_r == mofb_pkg::JOB_REFRESH) ? S_RESP : S_WRITE;
      end
      S_WRITE: begin
        cmd.mem_wr = 1'b1;
        if (status.walk_last) begin
          state_nxt = S_RESP;
        end else begin
          cmd.walk_step = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_RESP: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      job_r   <= mofb_pkg::JOB_NONE;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

endmodule

// File: hw/rtl/mofb_datapath.sv
// Datapath of the monochrome OLED frame buffer: byte walker, store,
// refresh position and result register. Depends on mofb_pkg and mofb_ram.
module mofb_datapath #(
  parameter int COLUMNS = mofb_pkg::DEF_COLUMNS,
  parameter int PAGES   = mofb_pkg::DEF_PAGES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [2:0]            in_operation,
  input  logic [7:0]            in_x,
  input  logic [7:0]            in_y,
  input  logic [7:0]            in_x_end,
  input  logic [7:0]            in_y_end,
  input  logic                  in_light,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_is_command,
  output logic                  out_carries_byte,
  output logic                  out_frame_end,
  input  mofb_pkg::mofb_cmd_t    cmd,
  output mofb_pkg::mofb_status_t status
);

  localparam int ROWS   = PAGES * 8;
  localparam int DEPTH  = COLUMNS * PAGES;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(COLUMNS + 3);

  localparam logic [7:0]        X_MAX     = 8'(COLUMNS - 1);
  localparam logic [7:0]        Y_MAX     = 8'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);
  localparam logic [SLOT_W-1:0] SLOT_PAGE_CMD = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_COL_LOW  = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_COL_HIGH = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_DATA     = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_LAST     = SLOT_W'(COLUMNS + 2);

  // Walk registers: current byte and the bounds of the region.
  logic [COL_W-1:0]  col_r, col_start_r, col_stop_r;
  logic [PAGE_W-1:0] page_r, page_stop_r;
  logic [7:0]        y_lo_r, y_hi_r;
  logic              light_r;

  // Values loaded into the walk registers when an item is accepted.
  logic [COL_W-1:0]  col_nxt, col_stop_nxt;
  logic [PAGE_W-1:0] page_nxt, page_stop_nxt;
  logic [7:0]        y_lo_nxt, y_hi_nxt;
  logic              light_nxt;

  // Refresh stream position.
  logic [PAGE_W-1:0] rpage_r;
  logic [SLOT_W-1:0] slot_r;

  // Result register.
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_is_command_r, out_carries_byte_r, out_frame_end_r;

  logic              x_ok, y_ok;
  logic [7:0]        x_clamp, y_clamp;
  mofb_pkg::job_t    job;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        rdata, mask, wdata, modified;
  logic [7:0]        row;

  // Decode the offered item into a job and its walk region.
  always_comb begin
    x_ok    = (in_x <= X_MAX);
    y_ok    = (in_y <= Y_MAX);
    x_clamp = (in_x_end > X_MAX) ? X_MAX : in_x_end;
    y_clamp = (in_y_end > Y_MAX) ? Y_MAX : in_y_end;

    col_nxt       = COL_W'(in_x);
    col_stop_nxt  = COL_W'(in_x);
    page_nxt      = PAGE_W'(in_y >> 3);
    page_stop_nxt = PAGE_W'(in_y >> 3);
    y_lo_nxt      = in_y;
    y_hi_nxt      = in_y;
    light_nxt     = (in_operation == mofb_pkg::OP_SET_PIXEL);

    unique case (in_operation) inside
      mofb_pkg::OP_SET_PIXEL, mofb_pkg::OP_CLEAR_PIXEL: begin
        job = (x_ok && y_ok) ? mofb_pkg::JOB_RMW : mofb_pkg::JOB_NONE;
      end
      mofb_pkg::OP_FILL_RECT: begin
        job = (x_ok && y_ok && (in_x < in_x_end) && (in_y < in_y_end)) ?
              mofb_pkg::JOB_RMW : mofb_pkg::JOB_NONE;
        col_stop_nxt  = COL_W'(x_clamp);
        page_stop_nxt = PAGE_W'(y_clamp >> 3);
        y_hi_nxt      = in_y_end;
        light_nxt     = in_light;
      end
      mofb_pkg::OP_CLEAR_ALL: begin
        job           = mofb_pkg::JOB_CLEAR;
        col_nxt       = '0;
        col_stop_nxt  = COL_LAST;
        page_nxt      = '0;
        page_stop_nxt = PAGE_LAST;
      end
      mofb_pkg::OP_REFRESH: begin
        job      = mofb_pkg::JOB_REFRESH;
        col_nxt  = (slot_r >= SLOT_DATA) ? COL_W'(slot_r - SLOT_DATA) : '0;
        page_nxt = rpage_r;
      end
      default: job = mofb_pkg::JOB_NONE;
    endcase
  end

  // Walk registers; reset sets up the clearing pass over the whole store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      col_start_r <= '0;
      col_stop_r  <= COL_LAST;
      page_r      <= '0;
      page_stop_r <= PAGE_LAST;
    end else if (cmd.capture) begin
      col_r       <= col_nxt;
      col_start_r <= col_nxt;
      col_stop_r  <= col_stop_nxt;
      page_r      <= page_nxt;
      page_stop_r <= page_stop_nxt;
    end else if (cmd.walk_step) begin
      if (col_r == col_stop_r) begin
        col_r  <= col_start_r;
        page_r <= page_r + PAGE_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // Row range and fill value of the item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      y_lo_r  <= y_lo_nxt;
      y_hi_r  <= y_hi_nxt;
      light_r <= light_nxt;
    end
  end

  // Store address and the read-modify-write byte.
  always_comb begin
    addr = ADDR_W'(page_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
    for (int b = 0; b < 8; b++) begin
      row     = 8'({page_r, 3'(b)});
      mask[b] = (row >= y_lo_r) && (row <= y_hi_r);
    end
    modified = light_r ? (rdata | mask) : (rdata & ~mask);
    wdata    = cmd.mem_clr ? '0 : modified;
  end

  mofb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.mem_wr | cmd.mem_clr),
    .waddr (addr),
    .wdata (wdata),
    .re    (cmd.mem_rd),
    .raddr (addr),
    .rdata (rdata)
  );

  // Refresh position advances when a refresh result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpage_r <= '0;
      slot_r  <= '0;
    end else if (cmd.load_out && cmd.refresh) begin
      if (slot_r == SLOT_LAST) begin
        slot_r  <= '0;
        rpage_r <= (rpage_r == PAGE_LAST) ? '0 : rpage_r + PAGE_W'(1);
      end else begin
        slot_r <= slot_r + SLOT_W'(1);
      end
    end
  end

  // Result valid flag; a new result may be loaded while the old one transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte_r         <= '0;
      out_is_command_r   <= 1'b0;
      out_carries_byte_r <= cmd.refresh;
      out_frame_end_r    <= 1'b0;
      if (cmd.refresh) begin
        out_is_command_r <= (slot_r < SLOT_DATA);
        out_frame_end_r  <= (slot_r == SLOT_LAST) && (rpage_r == PAGE_LAST);
        case (slot_r)
          SLOT_PAGE_CMD: out_byte_r <= mofb_pkg::CMD_PAGE_BASE + 8'(rpage_r);
          SLOT_COL_LOW:  out_byte_r <= mofb_pkg::CMD_COL_LOW;
          SLOT_COL_HIGH: out_byte_r <= mofb_pkg::CMD_COL_HIGH;
          default:       out_byte_r <= rdata;
        endcase
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_is_command   = out_is_command_r;
  assign out_carries_byte = out_carries_byte_r;
  assign out_frame_end    = out_frame_end_r;

  assign status.in_job    = job;
  assign status.walk_last = (col_r == col_stop_r) && (page_r == page_stop_r);
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

// File: hw/rtl/mono_oled_frame_buffer.sv
// Top level of the monochrome OLED frame buffer.
// Depends on mofb_pkg, mofb_ctrl, mofb_datapath (with mofb_ram) and the assertion header.
//
// Frame store for a page-mode OLED panel of COLUMNS x (PAGES*8) points, kept
// as PAGES pages of COLUMNS column bytes in one byte RAM with a write port and
// a read port. Each accepted item returns exactly one result. An unused code or
// an item that touches nothing goes straight to its result. Each byte of a set
// or clear pixel or a rectangle fill is a read-modify-write through the RAM, a
// read and then a write; a refresh item reads one byte, and clear all clears
// one byte per cycle. After reset the block runs a clearing pass over the whole
// store before it takes the first item. The result register lets a new item
// be taken while the previous result waits for its transfer.
`include "mono_oled_frame_buffer_assert.svh"

module mono_oled_frame_buffer #(
  parameter int COLUMNS = mofb_pkg::DEF_COLUMNS,
  parameter int PAGES   = mofb_pkg::DEF_PAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_x,
  input  logic [7:0] in_y,
  input  logic [7:0] in_x_end,
  input  logic [7:0] in_y_end,
  input  logic       in_light,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_command,
  output logic       out_carries_byte,
  output logic       out_frame_end
);

  mofb_pkg::mofb_cmd_t    cmd;
  mofb_pkg::mofb_status_t status;

  // Sequencing of each item.
  mofb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Store, walker and result register.
  mofb_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_x_end         (in_x_end),
    .in_y_end         (in_y_end),
    .in_light         (in_light),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_is_command   (out_is_command),
    .out_carries_byte (out_carries_byte),
    .out_frame_end    (out_frame_end),
    .cmd              (cmd),
    .status           (status)
  );

  // A result is never loaded over one that has not been transferred.
  `MOFB_ASSERT_NOW(a_no_result_overwrite, cmd.load_out, status.out_free)
  // Every modify write is preceded by the read of the same byte.
  `MOFB_ASSERT_NOW(a_write_after_read, cmd.mem_wr, $past(cmd.mem_rd))
  // The store is never written while the block is waiting for an item.
  `MOFB_ASSERT_NOW(a_idle_no_write, in_ready, !cmd.mem_wr && !cmd.mem_clr)
  // A stalled result stays offered with its byte unchanged.
  `MOFB_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_byte))
  // A frame end marks a data byte of the refresh stream.
  `MOFB_ASSERT_NOW(a_frame_end_is_data, out_valid && out_frame_end,
    out_carries_byte && !out_is_command)

endmodule
